### rtl/gtfw_pkg.sv
package gtfw_pkg;

    localparam int SCREEN_W = 32;
    localparam int SCREEN_H = 8;
    localparam int NPIX     = SCREEN_W * SCREEN_H;
    localparam int ADDR_W   = $clog2(NPIX);

    localparam int GLYPH_N    = 5;
    localparam int GLYPH_BITS = GLYPH_N * GLYPH_N;
    localparam int CHAR_GAP   = 1;
    localparam int CHAR_PITCH = GLYPH_N + CHAR_GAP;

    // largest linear position a draw can reach, before the drop check
    localparam int POS_MAX = 255 * SCREEN_W + 255 + CHAR_PITCH * 255
                           + (GLYPH_N - 1) * SCREEN_W + (GLYPH_N - 1);
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int LEN_W   = 11;

    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [3:0] SLOT_COLON  = 4'd10;
    localparam logic [7:0] PIXEL_ON    = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DRAW,
        S_READ,
        S_DONE
    } t_state;

    function automatic logic [3:0] f_glyph_slot(input logic [7:0] code);
        logic [3:0] slot;
        slot = SLOT_COLON;
        if (code inside {[CHAR_ZERO:CHAR_NINE]}) begin
            slot = 4'(code - CHAR_ZERO);
        end
        return slot;
    endfunction

    // bit r*5+c is glyph row r, column c; rows concatenated bottom row first
    function automatic logic [GLYPH_BITS-1:0] f_glyph_bits(input logic [3:0] slot);
        logic [GLYPH_BITS-1:0] g;
        case (slot)
            4'd0:    g = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
            4'd1:    g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            4'd2:    g = {5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F};
            4'd3:    g = {5'h1F, 5'h10, 5'h1F, 5'h10, 5'h1F};
            4'd4:    g = {5'h08, 5'h08, 5'h1F, 5'h09, 5'h0E};
            4'd5:    g = {5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F};
            4'd6:    g = {5'h1F, 5'h11, 5'h1F, 5'h01, 5'h1F};
            4'd7:    g = {5'h04, 5'h08, 5'h08, 5'h10, 5'h1F};
            4'd8:    g = {5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F};
            4'd9:    g = {5'h10, 5'h10, 5'h1F, 5'h11, 5'h1F};
            default: g = {5'h00, 5'h04, 5'h00, 5'h04, 5'h00};
        endcase
        return g;
    endfunction

endpackage

### rtl/glyph_text_framebuffer_writer.sv
// draw: one glyph pixel written per cycle; nothing is drawn if string_length*GLYPH_N >= SCREEN_W
// clear: one entry zeroed per cycle
// read: the result comes from the registered read of the framebuffer
// one item at a time: the input is ready again in the same cycle as the result enters the output
// reset: synchronous, active low; a clearing pass over all SCREEN_W*SCREEN_H entries (256 here)
// follows reset, during which no item is accepted
module glyph_text_framebuffer_writer
    import gtfw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_row,
    input  logic [7:0] i_col,
    input  logic [7:0] i_char_index,
    input  logic [7:0] i_string_length,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_pixel_value,
    output logic       o_drawn
);

    logic               r_mem [NPIX];
    logic               r_rd_bit;

    t_state             r_state,     n_state;
    logic [ADDR_W-1:0]  r_addr,      n_addr;
    logic [POS_W-1:0]   r_pos,       n_pos;
    logic [2:0]         r_gr,        n_gr;
    logic [2:0]         r_gc,        n_gc;
    logic [GLYPH_BITS-1:0] r_glyph,  n_glyph;
    logic               r_init,      n_init;
    logic               r_rd_ok,     n_rd_ok;
    logic               r_drawn,     n_drawn;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_pix,   n_out_pix;
    logic               r_out_drawn, n_out_drawn;

    logic               w_en;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_data;
    logic               in_fire;
    logic [POS_W-1:0]   rd_lin;
    logic [LEN_W-1:0]   len_x5;

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_out_pix;
    assign o_drawn       = r_out_drawn;

    assign rd_lin = POS_W'(i_row) * POS_W'(SCREEN_W) + POS_W'(i_col);
    assign len_x5 = LEN_W'(i_string_length) * LEN_W'(GLYPH_N);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_bit <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_init      <= 1'b1;
            r_rd_ok     <= 1'b0;
            r_drawn     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_init      <= n_init;
            r_rd_ok     <= n_rd_ok;
            r_drawn     <= n_drawn;
            r_out_valid <= n_out_valid;
        end
        r_pos       <= n_pos;
        r_gr        <= n_gr;
        r_gc        <= n_gc;
        r_glyph     <= n_glyph;
        r_out_pix   <= n_out_pix;
        r_out_drawn <= n_out_drawn;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pos       = r_pos;
        n_gr        = r_gr;
        n_gc        = r_gc;
        n_glyph     = r_glyph;
        n_init      = r_init;
        n_rd_ok     = r_rd_ok;
        n_drawn     = r_drawn;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pix   = r_out_pix;
        n_out_drawn = r_out_drawn;
        w_en        = 1'b0;
        w_addr      = r_addr;
        w_data      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_rd_ok = 1'b0;
                    n_drawn = 1'b0;
                    case (i_mode)
                        MODE_DRAW: begin
                            if (len_x5 < LEN_W'(SCREEN_W)) begin
                                n_drawn = 1'b1;
                                n_pos   = POS_W'(i_row) * POS_W'(SCREEN_W)
                                        + POS_W'(i_col)
                                        + POS_W'(i_char_index) * POS_W'(CHAR_PITCH);
                                n_gr    = '0;
                                n_gc    = '0;
                                n_glyph = f_glyph_bits(f_glyph_slot(i_char_code));
                                n_state = S_DRAW;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLEAR;
                        end
                        MODE_READ: begin
                            n_rd_ok = (i_row < 8'(SCREEN_H)) && (i_col < 8'(SCREEN_W));
                            n_addr  = ADDR_W'(rd_lin);
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                w_en   = 1'b1;
                w_addr = r_addr;
                w_data = 1'b0;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(NPIX - 1)) begin
                    n_addr  = '0;
                    n_init  = 1'b0;
                    // the pass after reset gives no result
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end

            S_DRAW: begin
                // pixels past the last one are dropped
                w_en    = (r_pos < POS_W'(NPIX));
                w_addr  = ADDR_W'(r_pos);
                w_data  = r_glyph[0];
                n_glyph = r_glyph >> 1;
                if (r_gc == 3'(GLYPH_N - 1)) begin
                    n_gc  = '0;
                    n_gr  = r_gr + 3'd1;
                    n_pos = r_pos + POS_W'(SCREEN_W - (GLYPH_N - 1));
                    if (r_gr == 3'(GLYPH_N - 1)) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_gc  = r_gc + 3'd1;
                    n_pos = r_pos + POS_W'(1);
                end
            end

            S_READ: begin
                // memory read data lands in r_rd_bit at this edge
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = (r_rd_ok && r_rd_bit) ? PIXEL_ON : 8'd0;
                    n_out_drawn = r_drawn;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import gtfw_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int N_RANDOM   = 500;
    localparam int STALL_LEN  = 400;
    localparam int TAIL_WAIT  = 300;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] code;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] idx;
        logic [7:0] len;
    } t_glyph_req;

    typedef struct packed {
        logic [7:0] pixel;
        logic       drawn;
    } t_glyph_rsp;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_mode = MODE_DRAW;
    logic [7:0] i_char_code = '0;
    logic [7:0] i_row = '0;
    logic [7:0] i_col = '0;
    logic [7:0] i_char_index = '0;
    logic [7:0] i_string_length = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_pixel_value;
    logic       o_drawn;

    t_glyph_req req_q[$];
    t_glyph_rsp rsp_expect_q[$];
    t_glyph_req cur_req;
    logic [NPIX-1:0] fb_model = '0;
    int n_sent = 0;
    int n_err = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;

    glyph_text_framebuffer_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_char_index    (i_char_index),
        .i_string_length (i_string_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_value   (o_pixel_value),
        .o_drawn         (o_drawn)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // 5x5 font, row 0 in the low five bits, pixel c of a row at bit c
    function automatic logic [GLYPH_BITS-1:0] glyph_of(input logic [7:0] code);
        logic [4:0] r0, r1, r2, r3, r4;
        {r0, r1, r2, r3, r4} = {5'h00, 5'h04, 5'h00, 5'h04, 5'h00};
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            case (code - CHAR_ZERO)
                8'd0: {r0, r1, r2, r3, r4} = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
                8'd1: {r0, r1, r2, r3, r4} = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
                8'd2: {r0, r1, r2, r3, r4} = {5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F};
                8'd3: {r0, r1, r2, r3, r4} = {5'h1F, 5'h10, 5'h1F, 5'h10, 5'h1F};
                8'd4: {r0, r1, r2, r3, r4} = {5'h0E, 5'h09, 5'h1F, 5'h08, 5'h08};
                8'd5: {r0, r1, r2, r3, r4} = {5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F};
                8'd6: {r0, r1, r2, r3, r4} = {5'h1F, 5'h01, 5'h1F, 5'h11, 5'h1F};
                8'd7: {r0, r1, r2, r3, r4} = {5'h1F, 5'h10, 5'h08, 5'h08, 5'h04};
                8'd8: {r0, r1, r2, r3, r4} = {5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F};
                default: {r0, r1, r2, r3, r4} = {5'h1F, 5'h11, 5'h1F, 5'h10, 5'h10};
            endcase
        end
        return {r4, r3, r2, r1, r0};
    endfunction

    // updates the framebuffer copy and returns the result the block owes
    function automatic t_glyph_rsp render_item(input t_glyph_req q);
        t_glyph_rsp rsp;
        logic [GLYPH_BITS-1:0] g;
        int base;
        int pos;
        rsp = '0;
        case (q.mode)
            MODE_DRAW: begin
                if (int'(q.len) * GLYPH_N < SCREEN_W) begin
                    g = glyph_of(q.code);
                    // full-width start column, glyphs past the right edge wrap
                    base = int'(q.row) * SCREEN_W + int'(q.col) + CHAR_PITCH * int'(q.idx);
                    for (int r = 0; r < GLYPH_N; r++) begin
                        for (int c = 0; c < GLYPH_N; c++) begin
                            pos = base + r * SCREEN_W + c;
                            if (pos < NPIX) begin
                                fb_model[pos] = g[r * GLYPH_N + c];
                            end
                        end
                    end
                    rsp.drawn = 1'b1;
                end
            end
            MODE_CLEAR: begin
                fb_model = '0;
            end
            MODE_READ: begin
                if (int'(q.row) < SCREEN_H && int'(q.col) < SCREEN_W) begin
                    if (fb_model[int'(q.row) * SCREEN_W + int'(q.col)]) begin
                        rsp.pixel = PIXEL_ON;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // no idling at all while the middle stretch of items goes through
    function automatic bit take_gap();
        if (n_sent >= 250 && n_sent < 350) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 6;
    endfunction

    function automatic void add_item(input logic [1:0] mode, input logic [7:0] code,
                                     input int row, input int col, input int idx,
                                     input int len);
        t_glyph_req q;
        q.mode = mode;
        q.code = code;
        q.row  = 8'(row);
        q.col  = 8'(col);
        q.idx  = 8'(idx);
        q.len  = 8'(len);
        req_q.push_back(q);
    endfunction

    always @(posedge i_clk) begin : drive_proc
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rsp_expect_q.push_back(render_item(cur_req));
                n_sent++;
            end
            // hold the offered item until it is taken
            if (!(i_in_valid && !o_in_ready)) begin
                if (req_q.size() != 0 && !take_gap()) begin
                    cur_req = req_q.pop_front();
                    i_mode          <= cur_req.mode;
                    i_char_code     <= cur_req.code;
                    i_row           <= cur_req.row;
                    i_col           <= cur_req.col;
                    i_char_index    <= cur_req.idx;
                    i_string_length <= cur_req.len;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_glyph_rsp want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (rsp_expect_q.size() == 0) begin
                    $error("unexpected item: pixel_value %0d, drawn %0d", o_pixel_value, o_drawn);
                    n_err++;
                end else begin
                    want = rsp_expect_q.pop_front();
                    if (o_pixel_value !== want.pixel) begin
                        $error("pixel_value mismatch: expected %0d, actual %0d",
                               want.pixel, o_pixel_value);
                        n_err++;
                    end
                    if (o_drawn !== want.drawn) begin
                        $error("drawn mismatch: expected %0d, actual %0d", want.drawn, o_drawn);
                        n_err++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!stall_done && n_sent >= 120) begin
                stall_done = 1'b1;
                stall_left = STALL_LEN;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !take_gap();
            end
        end
    end

    initial begin : stim_proc
        int total;
        int pick;
        int r0;
        int c0;
        int len;
        int n_reads;

        // every digit, spaced along a string that runs past the right edge
        for (int d = 0; d < 10; d++) begin
            add_item(MODE_DRAW, CHAR_ZERO + 8'(d), 0, 0, d, 6);
        end
        add_item(MODE_DRAW, 8'h3A, 3, 2, 0, 0);
        add_item(MODE_DRAW, 8'hFF, 255, 255, 255, 1);
        add_item(MODE_DRAW, 8'h41, 6, 28, 0, 2);
        add_item(MODE_DRAW, 8'h35, 2, 3, 0, 7);
        add_item(MODE_DRAW, 8'h33, 2, 3, 0, 255);
        add_item(MODE_NONE, 8'hFF, 255, 255, 255, 255);
        add_item(MODE_READ, 8'h00, 0, 0, 0, 0);
        add_item(MODE_READ, 8'h00, 7, 31, 0, 0);
        add_item(MODE_READ, 8'h00, 8, 0, 0, 0);
        add_item(MODE_READ, 8'h00, 0, 32, 0, 0);
        add_item(MODE_READ, 8'hFF, 255, 255, 255, 255);
        add_item(MODE_READ, 8'h00, 4, 4, 0, 0);
        add_item(MODE_CLEAR, 8'h00, 0, 0, 0, 0);
        add_item(MODE_READ, 8'h00, 1, 0, 0, 0);

        total = req_q.size() + N_RANDOM;
        while (req_q.size() < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // a whole string, then reads over the area it covers
                len = $urandom_range(1, 6);
                r0  = $urandom_range(0, SCREEN_H + 1);
                c0  = $urandom_range(0, SCREEN_W - 1);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_item(MODE_DRAW, 8'($urandom), r0, c0, i, len);
                    end else begin
                        add_item(MODE_DRAW, CHAR_ZERO + 8'($urandom_range(0, 10)),
                                 r0, c0, i, len);
                    end
                end
                n_reads = $urandom_range(3, 8);
                for (int k = 0; k < n_reads; k++) begin
                    add_item(MODE_READ, 8'($urandom),
                             (r0 + $urandom_range(0, 5)) % SCREEN_H,
                             (c0 + $urandom_range(0, 6 * len)) % SCREEN_W,
                             $urandom_range(0, 255), $urandom_range(0, 255));
                end
            end else if (pick < 70) begin
                add_item(MODE_READ, 8'($urandom), $urandom_range(0, SCREEN_H - 1),
                         $urandom_range(0, SCREEN_W - 1), 0, 0);
            end else if (pick < 73) begin
                add_item(MODE_CLEAR, 8'($urandom), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
            end else begin
                add_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
            end
        end
        total = req_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < total) @(posedge i_clk);
        while (rsp_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (n_err == 0 && rsp_expect_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
